>>> design/okae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// okae_pkg
// Shared constants and codes for the ordered key array engine.
// ----------------------------------------------------------------------------
package okae_pkg;
  localparam int Depth    = 256;
  localparam int KeyWidth = 32;
  localparam int AddrW    = $clog2(Depth);
  localparam int CntW     = AddrW + 1;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpDelete = 3'd1;
  localparam logic [2:0] OpGet    = 3'd2;
  localparam logic [2:0] OpSet    = 3'd3;
  localparam logic [2:0] OpFind   = 3'd4;
  localparam logic [2:0] OpSort   = 3'd5;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
endpackage
`default_nettype wire

>>> design/ordered_key_array_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_key_array_engine
// Key array with insert/delete shifting, get/set, binary search and sort.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (valid_i/ready_o) carries op_i, index_i, key_i. One result
//    transfer (valid_o/ready_i) returns status_o, key_out_o, position_o, count_o
//    per input transfer, in order.
//  - One item at a time. Keys live in a single-port-write, registered-read RAM,
//    and every operation goes through that one memory port: get/set: one
//    access; insert: each entry from count-1 down to index is read and moved
//    up one place; delete: each entry above index is read and moved down one
//    place; find: binary search, one read per probe (at most log2(DEPTH)+1
//    probes); sort: insertion sort.
//  - ready_o is high only in idle; the result sits in an output register
//    until taken, and the next item is accepted once it has been.
//  - Reset clears the element count; the RAM itself is not cleared, entries
//    at or above count are never used.
//  - A stalled receiver holds the result and the block stays busy.
// ----------------------------------------------------------------------------
module ordered_key_array_engine
  import okae_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic [2:0]          op_i,
  input  wire logic [8:0]          index_i,
  input  wire logic [31:0]         key_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output logic [1:0]               status_o,
  output logic [31:0]              key_out_o,
  output logic [8:0]               position_o,
  output logic [8:0]               count_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR, S_RD_WAIT,
    S_FIND_RD, S_FIND_CMP, S_SRT_RDV, S_SRT_RDJ, S_SRT_CMP, S_SRT_PUT, S_OUT
  } state_e;

  state_e state_q;
  logic [KeyWidth-1:0] mem [Depth];
  logic [KeyWidth-1:0] rdata_q;
  logic [AddrW-1:0]    raddr;
  logic                re;
  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [KeyWidth-1:0] wdata;

  logic [CntW-1:0] cnt_q;
  logic [2:0]      op_q;
  logic [CntW-1:0] idx_q;
  logic [KeyWidth-1:0] key_q;
  logic [CntW-1:0] i_q;        // walk pointer / sort outer index
  logic [CntW-1:0] j_q;        // sort inner index
  logic [KeyWidth-1:0] v_q;    // sort element being placed
  logic signed [CntW:0] lo_q, hi_q;
  logic signed [CntW:0] mid;

  logic [1:0]      status_q;
  logic [31:0]     kout_q;
  logic [8:0]      pos_q;

  assign mid = (lo_q + hi_q) >>> 1;

  // memory port control
  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state_q)
      S_DISPATCH: begin
        re    = 1'b1;
        raddr = idx_q[AddrW-1:0];
        if (op_q == OpInsert) raddr = AddrW'(cnt_q - 1'b1);
        if (op_q == OpSort)   raddr = AddrW'(i_q);
        if (op_q == OpSet && idx_q < cnt_q) begin
          we    = 1'b1;
          waddr = idx_q[AddrW-1:0];
          wdata = key_q;
        end
      end
      S_INS_RD: begin
        re    = 1'b1;
        raddr = AddrW'(i_q - 1'b1);
      end
      S_INS_WR: begin
        we    = 1'b1;
        waddr = AddrW'(i_q);
        wdata = (i_q == idx_q) ? key_q : rdata_q;
      end
      S_DEL_RD: begin
        re    = 1'b1;
        raddr = AddrW'(i_q + 1'b1);
      end
      S_DEL_WR: begin
        we    = 1'b1;
        waddr = AddrW'(i_q);
        wdata = rdata_q;
      end
      S_FIND_RD: begin
        re    = 1'b1;
        raddr = AddrW'(mid[CntW-1:0]);
      end
      S_SRT_RDV: begin
        re    = 1'b1;
        raddr = AddrW'(i_q);
      end
      S_SRT_RDJ: begin
        re    = 1'b1;
        raddr = AddrW'(j_q - 1'b1);
      end
      S_SRT_CMP: begin
        if (j_q != '0 && rdata_q > v_q) begin
          we    = 1'b1;
          waddr = AddrW'(j_q);
          wdata = rdata_q;
        end
      end
      S_SRT_PUT: begin
        we    = 1'b1;
        waddr = AddrW'(j_q);
        wdata = v_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      op_q     <= '0;
      idx_q    <= '0;
      key_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      v_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      status_q <= StOk;
      kout_q   <= '0;
      pos_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            op_q     <= op_i;
            idx_q    <= CntW'(index_i);
            key_q    <= key_i;
            status_q <= StOk;
            kout_q   <= '0;
            pos_q    <= '0;
            i_q      <= CntW'(1);
            lo_q     <= '0;
            hi_q     <= (CntW+1)'($signed({1'b0, cnt_q}) - 1);
            state_q  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_q <= S_OUT;
          case (op_q)
            OpInsert: begin
              if (idx_q > cnt_q) status_q <= StRange;
              else if (cnt_q == CntW'(Depth)) status_q <= StFull;
              else if (idx_q == cnt_q) begin
                i_q     <= cnt_q;
                state_q <= S_INS_WR;
              end else begin
                i_q     <= cnt_q;
                state_q <= S_INS_WR; // rdata holds key[cnt-1]
              end
            end
            OpDelete, OpGet: begin
              if (idx_q >= cnt_q) status_q <= StRange;
              else state_q <= S_RD_WAIT;
            end
            OpSet: begin
              if (idx_q >= cnt_q) status_q <= StRange;
            end
            OpFind: begin
              if (cnt_q != '0) state_q <= S_FIND_RD;
            end
            OpSort: begin
              if (cnt_q > CntW'(1)) state_q <= S_SRT_RDV;
            end
            default: ;
          endcase
        end
        S_INS_WR: begin
          if (i_q == idx_q) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_OUT;
          end else begin
            i_q     <= i_q - 1'b1;
            state_q <= ((i_q - 1'b1) == idx_q) ? S_INS_WR : S_INS_RD;
          end
        end
        S_INS_RD: state_q <= S_INS_WR;
        S_RD_WAIT: begin
          kout_q <= rdata_q;
          if (op_q == OpDelete) begin
            i_q     <= idx_q;
            state_q <= (idx_q + 1'b1 < cnt_q) ? S_DEL_RD : S_OUT;
            if (idx_q + 1'b1 >= cnt_q) cnt_q <= cnt_q - 1'b1;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DEL_RD: state_q <= S_DEL_WR;
        S_DEL_WR: begin
          if (i_q + CntW'(2) < cnt_q) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_DEL_RD;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_OUT;
          end
        end
        S_FIND_RD: state_q <= S_FIND_CMP;
        S_FIND_CMP: begin
          if (rdata_q == key_q) begin
            pos_q   <= 9'(mid[CntW-1:0]);
            state_q <= S_OUT;
          end else begin
            if (rdata_q < key_q) lo_q <= (CntW+1)'(mid + 1);
            else hi_q <= (CntW+1)'(mid - 1);
            if (((rdata_q < key_q) ? (mid + 1) : lo_q) >
                ((rdata_q < key_q) ? hi_q : (mid - 1))) begin
              pos_q   <= 9'((rdata_q < key_q) ? (hi_q + 1) : mid);
              state_q <= S_OUT;
            end else begin
              state_q <= S_FIND_RD;
            end
          end
        end
        S_SRT_RDV: begin
          j_q     <= i_q;
          state_q <= S_SRT_RDJ;
        end
        S_SRT_RDJ: begin
          if (j_q == i_q) v_q <= rdata_q;
          state_q <= S_SRT_CMP;
        end
        S_SRT_CMP: begin
          if (j_q != '0 && rdata_q > v_q) begin
            j_q     <= j_q - 1'b1;
            state_q <= (j_q == CntW'(1)) ? S_SRT_PUT : S_SRT_RDJ;
          end else begin
            state_q <= S_SRT_PUT;
          end
        end
        S_SRT_PUT: begin
          if (i_q + 1'b1 < cnt_q) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SRT_RDV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: if (ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign ready_o    = (state_q == S_IDLE);
  assign valid_o    = (state_q == S_OUT);
  assign status_o   = status_q;
  assign key_out_o  = kout_q;
  assign position_o = pos_q;
  assign count_o    = 9'(cnt_q);

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("count above capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(count_o))
    else $error("result dropped while stalled");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |=> $stable(cnt_q) || !$past(ready_o))
    else $error("count moved while idle");
`endif

endmodule
`default_nettype wire
